### src/llsf_pkg.sv
// Shared widths, select codes and control/status structs for the
// least-squares line fit core. No dependencies.
package llsf_pkg;

  localparam int MAX_POINTS    = 4096;
  localparam int FRACTION_BITS = 32;

  localparam int IN_W      = 24;
  localparam int OUT_W     = 64;
  localparam int LOG_PTS   = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int PROD_W    = 2 * IN_W;
  localparam int SUM_W     = IN_W + LOG_PTS;
  localparam int SQ_W      = PROD_W + LOG_PTS;
  localparam int NUM_W     = SQ_W + SUM_W;
  localparam int DVD_W     = NUM_W + FRACTION_BITS + 1;
  localparam int REM_W     = NUM_W + 2;
  localparam int MUL_CNT_W = $clog2(SQ_W + 1);
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_N_XX = 3'd0;
  localparam mul_sel_t MUL_X_X  = 3'd1;
  localparam mul_sel_t MUL_N_XY = 3'd2;
  localparam mul_sel_t MUL_X_Y  = 3'd3;
  localparam mul_sel_t MUL_XX_Y = 3'd4;
  localparam mul_sel_t MUL_X_XY = 3'd5;

  typedef logic [1:0] diff_sel_t;
  localparam diff_sel_t DIFF_DEN  = 2'd0;
  localparam diff_sel_t DIFF_NUMA = 2'd1;
  localparam diff_sel_t DIFF_NUMB = 2'd2;

  typedef logic div_sel_t;
  localparam div_sel_t DIV_SLOPE  = 1'b0;
  localparam div_sel_t DIV_OFFSET = 1'b1;

  typedef struct packed {
    logic      pt_ld;
    logic      acc_en;
    logic      clr;
    logic      mul_start;
    mul_sel_t  mul_sel;
    logic      t1_ld;
    logic      diff_ld;
    diff_sel_t diff_sel;
    logic      div_start;
    div_sel_t  div_sel;
    logic      quo_ld;
    logic      deg_ld;
    logic      pub;
  } llsf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic den_zero;
  } llsf_sts_t;

endpackage

### src/llsf_point_if.sv
// Input channel: one (x, y) point word with a last-point mark.
// Depends on llsf_pkg.
interface llsf_point_if;
  logic                            valid;
  logic                            ready;
  logic signed [llsf_pkg::IN_W-1:0] x_value;
  logic signed [llsf_pkg::IN_W-1:0] y_value;
  logic                            last_point;

  modport source (output valid, output x_value, output y_value, output last_point,
                  input ready);
  modport sink   (input valid, input x_value, input y_value, input last_point,
                  output ready);
endinterface

### src/llsf_fit_if.sv
// Result channel: one fitted line word (slope, offset, flags).
// Depends on llsf_pkg.
interface llsf_fit_if;
  logic                             valid;
  logic                             ready;
  logic signed [llsf_pkg::OUT_W-1:0] slope;
  logic signed [llsf_pkg::OUT_W-1:0] offset;
  logic                             degenerate;
  logic                             saturated;

  modport source (output valid, output slope, output offset, output degenerate,
                  output saturated, input ready);
  modport sink   (input valid, input slope, input offset, input degenerate,
                  input saturated, output ready);
endinterface

### src/llsf_mul.sv
// Sequential shift-add signed multiplier, one multiplier bit per cycle.
// Depends on llsf_pkg.
module llsf_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [llsf_pkg::SQ_W-1:0]  op_a,
  input  logic signed [llsf_pkg::SQ_W-1:0]  op_b,
  output logic                              done,
  output logic signed [llsf_pkg::NUM_W-1:0] prod
);

  logic signed [llsf_pkg::NUM_W-1:0]  mcand_r, mcand_nxt;
  logic signed [llsf_pkg::NUM_W-1:0]  acc_r, acc_nxt;
  logic [llsf_pkg::SQ_W-1:0]          mplier_r, mplier_nxt;
  logic [llsf_pkg::MUL_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;

  always_comb begin
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      mcand_nxt  = op_b[llsf_pkg::SQ_W-1] ? -llsf_pkg::NUM_W'(op_a)
                                          : llsf_pkg::NUM_W'(op_a);
      mplier_nxt = $unsigned(op_b[llsf_pkg::SQ_W-1] ? -op_b : op_b);
      acc_nxt    = '0;
      cnt_nxt    = llsf_pkg::MUL_CNT_W'(llsf_pkg::SQ_W);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == llsf_pkg::MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### src/llsf_div.sv
// Restoring divider, one quotient bit per cycle, with round-half-away
// fixed-point scaling and 64-bit saturation. Depends on llsf_pkg.
module llsf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [llsf_pkg::NUM_W-1:0] num,
  input  logic signed [llsf_pkg::NUM_W-1:0] den,
  output logic                              done,
  output logic [llsf_pkg::OUT_W-1:0]        quo,
  output logic                              sat
);

  logic                             neg_r, neg_nxt;
  logic [llsf_pkg::NUM_W-1:0]       magn_r, magn_nxt;
  logic [llsf_pkg::NUM_W-1:0]       magd_r, magd_nxt;
  logic [llsf_pkg::DVD_W-1:0]       dvd_r, dvd_nxt;
  logic [llsf_pkg::REM_W-1:0]       dsr_r, dsr_nxt;
  logic [llsf_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [llsf_pkg::OUT_W-1:0]       q_r, q_nxt;
  logic                             hi_r, hi_nxt;
  logic [llsf_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             prep_r, prep_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [llsf_pkg::REM_W-1:0]       rem_sh;
  logic                             ge;
  logic                             over;

  always_comb begin
    neg_nxt  = neg_r;
    magn_nxt = magn_r;
    magd_nxt = magd_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    hi_nxt   = hi_r;
    cnt_nxt  = cnt_r;
    prep_nxt = 1'b0;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[llsf_pkg::REM_W-2:0], dvd_r[llsf_pkg::DVD_W-1]};
    ge       = (rem_sh >= dsr_r);
    if (start) begin
      neg_nxt  = num[llsf_pkg::NUM_W-1] ^ den[llsf_pkg::NUM_W-1];
      magn_nxt = $unsigned(num[llsf_pkg::NUM_W-1] ? -num : num);
      magd_nxt = $unsigned(den[llsf_pkg::NUM_W-1] ? -den : den);
      prep_nxt = 1'b1;
    end else if (prep_r) begin
      dvd_nxt  = (llsf_pkg::DVD_W'(magn_r) << (llsf_pkg::FRACTION_BITS + 1))
               + llsf_pkg::DVD_W'(magd_r);
      dsr_nxt  = llsf_pkg::REM_W'(magd_r) << 1;
      rem_nxt  = '0;
      q_nxt    = '0;
      hi_nxt   = 1'b0;
      cnt_nxt  = llsf_pkg::DIV_CNT_W'(llsf_pkg::DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sh - dsr_r : rem_sh;
      q_nxt   = {q_r[llsf_pkg::OUT_W-2:0], ge};
      hi_nxt  = hi_r | q_r[llsf_pkg::OUT_W-1];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == llsf_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      over = hi_r | (q_r[llsf_pkg::OUT_W-1] & (|q_r[llsf_pkg::OUT_W-2:0]));
      quo  = over ? llsf_pkg::SAT_MIN : -q_r;
    end else begin
      over = hi_r | q_r[llsf_pkg::OUT_W-1];
      quo  = over ? llsf_pkg::SAT_MAX : q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      prep_r <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      prep_r <= prep_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    magn_r <= magn_nxt;
    magd_r <= magd_nxt;
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    hi_r   <= hi_nxt;
  end

  assign done = done_r;
  assign sat  = over;

endmodule

### src/llsf_dp.sv
// Datapath: point products, running sums, shared multiplier and divider,
// numerator/denominator registers and result registers. Depends on llsf_pkg.
module llsf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  llsf_pkg::llsf_cmd_t               cmd,
  output llsf_pkg::llsf_sts_t               sts,
  input  logic signed [llsf_pkg::IN_W-1:0]  x_value,
  input  logic signed [llsf_pkg::IN_W-1:0]  y_value,
  output logic signed [llsf_pkg::OUT_W-1:0] slope,
  output logic signed [llsf_pkg::OUT_W-1:0] offset,
  output logic                              degenerate,
  output logic                              saturated
);

  logic signed [llsf_pkg::IN_W-1:0]   px_r, py_r;
  logic signed [llsf_pkg::PROD_W-1:0] pxx_r, pxy_r;
  logic [llsf_pkg::CNT_W-1:0]         cnt_r;
  logic signed [llsf_pkg::SUM_W-1:0]  sx_r, sy_r;
  logic signed [llsf_pkg::SQ_W-1:0]   sxx_r, sxy_r;
  logic signed [llsf_pkg::NUM_W-1:0]  t1_r, den_r, numa_r, numb_r;
  logic signed [llsf_pkg::OUT_W-1:0]  slope_wk_r, offset_wk_r, slope_r, offset_r;
  logic                               deg_wk_r, sat_wk_r, deg_r, sat_r;

  logic signed [llsf_pkg::SQ_W-1:0]   op_a, op_b;
  logic signed [llsf_pkg::SQ_W-1:0]   n_ext, sx_ext, sy_ext;
  logic signed [llsf_pkg::NUM_W-1:0]  prod, diff, div_num;
  logic                               mul_done, div_done, div_sat;
  logic [llsf_pkg::OUT_W-1:0]         quo;

  assign n_ext  = $signed(llsf_pkg::SQ_W'(cnt_r));
  assign sx_ext = llsf_pkg::SQ_W'(sx_r);
  assign sy_ext = llsf_pkg::SQ_W'(sy_r);

  always_comb begin
    case (cmd.mul_sel)
      llsf_pkg::MUL_N_XX: begin op_a = n_ext;  op_b = sxx_r;  end
      llsf_pkg::MUL_X_X:  begin op_a = sx_ext; op_b = sx_ext; end
      llsf_pkg::MUL_N_XY: begin op_a = n_ext;  op_b = sxy_r;  end
      llsf_pkg::MUL_X_Y:  begin op_a = sx_ext; op_b = sy_ext; end
      llsf_pkg::MUL_XX_Y: begin op_a = sxx_r;  op_b = sy_ext; end
      llsf_pkg::MUL_X_XY: begin op_a = sx_ext; op_b = sxy_r;  end
      default:            begin op_a = '0;     op_b = '0;     end
    endcase
  end

  llsf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .op_a  (op_a),
    .op_b  (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign diff    = t1_r - prod;
  assign div_num = (cmd.div_sel == llsf_pkg::DIV_SLOPE) ? numa_r : numb_r;

  llsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo),
    .sat   (div_sat)
  );

  always_ff @(posedge clk) begin
    if (cmd.pt_ld) begin
      px_r  <= x_value;
      py_r  <= y_value;
      pxx_r <= llsf_pkg::PROD_W'(x_value) * llsf_pkg::PROD_W'(x_value);
      pxy_r <= llsf_pkg::PROD_W'(x_value) * llsf_pkg::PROD_W'(y_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      sxy_r <= '0;
    end else if (cmd.acc_en && (cnt_r < llsf_pkg::CNT_W'(llsf_pkg::MAX_POINTS))) begin
      cnt_r <= cnt_r + 1'b1;
      sx_r  <= sx_r + llsf_pkg::SUM_W'(px_r);
      sy_r  <= sy_r + llsf_pkg::SUM_W'(py_r);
      sxx_r <= sxx_r + llsf_pkg::SQ_W'(pxx_r);
      sxy_r <= sxy_r + llsf_pkg::SQ_W'(pxy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.t1_ld) begin
      t1_r <= prod;
    end
    if (cmd.diff_ld) begin
      case (cmd.diff_sel)
        llsf_pkg::DIFF_DEN:  den_r  <= diff;
        llsf_pkg::DIFF_NUMA: numa_r <= diff;
        llsf_pkg::DIFF_NUMB: numb_r <= diff;
        default: ;
      endcase
    end
    if (cmd.deg_ld) begin
      slope_wk_r  <= '0;
      offset_wk_r <= '0;
      deg_wk_r    <= 1'b1;
      sat_wk_r    <= 1'b0;
    end else if (cmd.quo_ld) begin
      if (cmd.div_sel == llsf_pkg::DIV_SLOPE) begin
        slope_wk_r <= $signed(quo);
        deg_wk_r   <= 1'b0;
        sat_wk_r   <= div_sat;
      end else begin
        offset_wk_r <= $signed(quo);
        sat_wk_r    <= sat_wk_r | div_sat;
      end
    end
    if (cmd.pub) begin
      slope_r  <= slope_wk_r;
      offset_r <= offset_wk_r;
      deg_r    <= deg_wk_r;
      sat_r    <= sat_wk_r;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.den_zero = (den_r == '0);

  assign slope      = slope_r;
  assign offset     = offset_r;
  assign degenerate = deg_r;
  assign saturated  = sat_r;

endmodule

### src/llsf_ctrl.sv
// Controller: accepts point words, sequences the six products and two
// divisions, publishes the result word. Depends on llsf_pkg.
module llsf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output llsf_pkg::llsf_cmd_t cmd,
  input  llsf_pkg::llsf_sts_t sts
);

  localparam logic [2:0] S_ACC    = 3'd0;
  localparam logic [2:0] S_DRAIN  = 3'd1;
  localparam logic [2:0] S_MSTART = 3'd2;
  localparam logic [2:0] S_MWAIT  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_DSTART = 3'd5;
  localparam logic [2:0] S_DWAIT  = 3'd6;
  localparam logic [2:0] S_PUB    = 3'd7;

  logic [2:0]          state_r, state_nxt;
  llsf_pkg::mul_sel_t  j_r, j_nxt;
  llsf_pkg::div_sel_t  d_r, d_nxt;
  logic                pend_r;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    d_nxt         = d_r;
    cmd           = '0;
    cmd.mul_sel   = j_r;
    cmd.div_sel   = d_r;
    cmd.diff_sel  = llsf_pkg::DIFF_DEN;
    cmd.acc_en    = pend_r;
    in_ready      = (state_r == S_ACC);
    cmd.pt_ld     = in_valid && in_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_ACC: begin
        if (cmd.pt_ld && in_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        j_nxt     = llsf_pkg::MUL_N_XX;
        state_nxt = S_MSTART;
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.mul_done) begin
          case (j_r)
            llsf_pkg::MUL_X_X: begin
              cmd.diff_ld  = 1'b1;
              cmd.diff_sel = llsf_pkg::DIFF_DEN;
            end
            llsf_pkg::MUL_X_Y: begin
              cmd.diff_ld  = 1'b1;
              cmd.diff_sel = llsf_pkg::DIFF_NUMA;
            end
            llsf_pkg::MUL_X_XY: begin
              cmd.diff_ld  = 1'b1;
              cmd.diff_sel = llsf_pkg::DIFF_NUMB;
            end
            default: cmd.t1_ld = 1'b1;
          endcase
          j_nxt = j_r + 3'd1;
          if (j_r == llsf_pkg::MUL_X_X) begin
            state_nxt = S_CHECK;
          end else if (j_r == llsf_pkg::MUL_X_XY) begin
            d_nxt     = llsf_pkg::DIV_SLOPE;
            state_nxt = S_DSTART;
          end else begin
            state_nxt = S_MSTART;
          end
        end
      end
      S_CHECK: begin
        if (sts.den_zero) begin
          cmd.deg_ld = 1'b1;
          state_nxt  = S_PUB;
        end else begin
          state_nxt = S_MSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.quo_ld = 1'b1;
          if (d_r == llsf_pkg::DIV_SLOPE) begin
            d_nxt     = llsf_pkg::DIV_OFFSET;
            state_nxt = S_DSTART;
          end else begin
            state_nxt = S_PUB;
          end
        end
      end
      S_PUB: begin
        if (!out_valid_r || out_ready) begin
          cmd.pub       = 1'b1;
          cmd.clr       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      j_r         <= llsf_pkg::MUL_N_XX;
      d_r         <= llsf_pkg::DIV_SLOPE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      d_r         <= d_nxt;
      pend_r      <= cmd.pt_ld;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### src/linear_least_squares_fit_core.sv
// Least-squares line fit core. Points are taken one word per cycle while
// the core is accumulating; the sums are updated in the cycle after each
// point is taken (one 24x24 multiply pair). After the last point the fit
// is run by the bit-serial multiplier and divider; a degenerate set
// finishes after the first two products.
// Synchronous active-low reset clears the sums, the sequencer and valid.
module linear_least_squares_fit_core (
  input  logic         clk,
  input  logic         rst_n,
  llsf_point_if.sink   in_pt,
  llsf_fit_if.source   out_fit
);

  llsf_pkg::llsf_cmd_t cmd;
  llsf_pkg::llsf_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  llsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pt.valid),
    .in_last   (in_pt.last_point),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_fit.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  llsf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .x_value    (in_pt.x_value),
    .y_value    (in_pt.y_value),
    .slope      (out_fit.slope),
    .offset     (out_fit.offset),
    .degenerate (out_fit.degenerate),
    .saturated  (out_fit.saturated)
  );

  assign in_pt.ready   = in_ready;
  assign out_fit.valid = out_valid;

  a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pub |-> (!out_valid || out_fit.ready))
    else $error("result published over a word still waiting");

  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.mul_done && sts.div_done))
    else $error("multiplier and divider finished together");

  a_start_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_start || cmd.div_start) |-> !in_ready)
    else $error("arithmetic started while accepting points");

  a_acc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pt_ld |=> (cmd.acc_en && !cmd.clr))
    else $error("accepted point not accumulated");

endmodule

### tb/sv/llsf_fit_checker.sv
// Checker for the line fit core: watches the point and fit channels, keeps a
// predicted copy of the sums and compares every fit word. Depends on llsf_pkg.
`timescale 1ns / 1ps
module llsf_fit_checker (
  input  logic  clk,
  input  logic  rst_n,
  llsf_point_if pt_mon,
  llsf_fit_if   fit_mon,
  output int    fail_count,
  output int    pending_fits
);

  localparam int WIDE = 256;

  typedef struct packed {
    logic signed [llsf_pkg::OUT_W-1:0] slope;
    logic signed [llsf_pkg::OUT_W-1:0] offset;
    logic                              degenerate;
    logic                              saturated;
  } fit_word_t;

  logic        [llsf_pkg::CNT_W-1:0] pts_held;
  logic signed [63:0]                sum_x;
  logic signed [63:0]                sum_y;
  logic signed [63:0]                sum_xx;
  logic signed [63:0]                sum_xy;

  logic signed [WIDE-1:0] n_w;
  logic signed [WIDE-1:0] sx_w;
  logic signed [WIDE-1:0] sy_w;
  logic signed [WIDE-1:0] sxx_w;
  logic signed [WIDE-1:0] sxy_w;
  logic signed [WIDE-1:0] den;
  logic signed [WIDE-1:0] num_a;
  logic signed [WIDE-1:0] num_b;
  logic                   clip;

  fit_word_t fit_queue[$];
  fit_word_t want;
  fit_word_t next_fit;
  int        fit_index;

  function automatic logic [llsf_pkg::OUT_W-1:0] fixed_quotient(
      input logic signed [WIDE-1:0] num,
      input logic signed [WIDE-1:0] dvs,
      inout logic sat);
    logic [WIDE-1:0] n_mag;
    logic [WIDE-1:0] d_mag;
    logic [WIDE-1:0] q;
    logic            neg;
    neg   = num[WIDE-1] ^ dvs[WIDE-1];
    n_mag = num[WIDE-1] ? -num : num;
    d_mag = dvs[WIDE-1] ? -dvs : dvs;
    // round half away from zero on the magnitude
    q = ((n_mag << (llsf_pkg::FRACTION_BITS + 1)) + d_mag) / (d_mag << 1);
    if (!neg) begin
      if (q > WIDE'(llsf_pkg::SAT_MAX)) begin
        sat = 1'b1;
        return llsf_pkg::SAT_MAX;
      end
      return q[llsf_pkg::OUT_W-1:0];
    end
    if (q > WIDE'(llsf_pkg::SAT_MIN)) begin
      sat = 1'b1;
      return llsf_pkg::SAT_MIN;
    end
    return -q[llsf_pkg::OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("fit %0d %s: got 0x%h want 0x%h", fit_index, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pts_held = '0;
      sum_x    = '0;
      sum_y    = '0;
      sum_xx   = '0;
      sum_xy   = '0;
      fit_queue.delete();
      fit_index = 0;
      fail_count = 0;
      pending_fits <= 0;
    end else begin
      if (fit_mon.valid && fit_mon.ready) begin
        if (fit_queue.size() == 0) begin
          report_mismatch("word with no fit pending", fit_mon.slope, '0);
        end else begin
          want = fit_queue.pop_front();
          if (fit_mon.slope !== want.slope)
            report_mismatch("slope", fit_mon.slope, want.slope);
          if (fit_mon.offset !== want.offset)
            report_mismatch("offset", fit_mon.offset, want.offset);
          if (fit_mon.degenerate !== want.degenerate)
            report_mismatch("degenerate", 64'(fit_mon.degenerate), 64'(want.degenerate));
          if (fit_mon.saturated !== want.saturated)
            report_mismatch("saturated", 64'(fit_mon.saturated), 64'(want.saturated));
        end
        fit_index++;
      end

      if (pt_mon.valid && pt_mon.ready) begin
        // drop points beyond the set capacity
        if (pts_held < llsf_pkg::CNT_W'(llsf_pkg::MAX_POINTS)) begin
          pts_held = pts_held + 1'b1;
          sum_x    = sum_x + 64'(pt_mon.x_value);
          sum_y    = sum_y + 64'(pt_mon.y_value);
          sum_xx   = sum_xx + 64'(pt_mon.x_value) * 64'(pt_mon.x_value);
          sum_xy   = sum_xy + 64'(pt_mon.x_value) * 64'(pt_mon.y_value);
        end
        if (pt_mon.last_point) begin
          n_w   = WIDE'(pts_held);
          sx_w  = WIDE'(sum_x);
          sy_w  = WIDE'(sum_y);
          sxx_w = WIDE'(sum_xx);
          sxy_w = WIDE'(sum_xy);
          den   = n_w * sxx_w - sx_w * sx_w;
          next_fit = '0;
          if (den == '0) begin
            next_fit.degenerate = 1'b1;
          end else begin
            clip  = 1'b0;
            num_a = n_w * sxy_w - sx_w * sy_w;
            num_b = sxx_w * sy_w - sx_w * sxy_w;
            next_fit.slope     = fixed_quotient(num_a, den, clip);
            next_fit.offset    = fixed_quotient(num_b, den, clip);
            next_fit.saturated = clip;
          end
          fit_queue.push_back(next_fit);
          pts_held = '0;
          sum_x    = '0;
          sum_y    = '0;
          sum_xx   = '0;
          sum_xy   = '0;
        end
      end
      pending_fits <= fit_queue.size();
    end
  end

endmodule

### tb/sv/linear_least_squares_fit_core_tb.sv
// Top of the line fit core testbench: clock, reset, point stimulus and fit
// back-pressure, verdict. Depends on llsf_pkg, both channel interfaces, the checker.
`timescale 1ns / 1ps
module linear_least_squares_fit_core_tb;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int TIMEOUT_CYCLES = 5_000_000;
  localparam int DRAIN_CYCLES   = 800;
  localparam int PHASE_ITEMS    = 330;

  localparam logic signed [llsf_pkg::IN_W-1:0] COORD_MAX =
    {1'b0, {(llsf_pkg::IN_W-1){1'b1}}};
  localparam logic signed [llsf_pkg::IN_W-1:0] COORD_MIN =
    {1'b1, {(llsf_pkg::IN_W-1){1'b0}}};

  typedef enum int {SET_SINGLE, SET_FLAT_X, SET_EXTREME, SET_NOISE, SET_LINE} set_shape_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_fits;
  int   sender_idle_pct;
  int   sink_stall_pct;
  int   items_sent;

  llsf_point_if in_pt();
  llsf_fit_if   out_fit();

  linear_least_squares_fit_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (in_pt),
    .out_fit (out_fit)
  );

  llsf_fit_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pt_mon       (in_pt),
    .fit_mon      (out_fit),
    .fail_count   (fail_count),
    .pending_fits (pending_fits)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("[linear_least_squares_fit_core] ERROR");
    $finish;
  end

  initial begin
    out_fit.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_fit.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic logic signed [llsf_pkg::IN_W-1:0] pick_extreme();
    case ($urandom_range(6))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return llsf_pkg::IN_W'(1);
      4: return llsf_pkg::IN_W'(-1);
      5: return COORD_MAX - llsf_pkg::IN_W'(1);
      default: return COORD_MIN + llsf_pkg::IN_W'(1);
    endcase
  endfunction

  task automatic send_point(input logic signed [llsf_pkg::IN_W-1:0] x,
                            input logic signed [llsf_pkg::IN_W-1:0] y,
                            input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
    in_pt.valid      <= 1'b1;
    in_pt.x_value    <= x;
    in_pt.y_value    <= y;
    in_pt.last_point <= last;
    @(posedge clk);
    while (!in_pt.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_fits_drained();
    in_pt.valid <= 1'b0;
    @(posedge clk);
    while (pending_fits != 0) @(posedge clk);
  endtask

  task automatic send_random_set();
    set_shape_t                        shape;
    int                                roll;
    int                                size;
    int                                i;
    int                                dx;
    int                                slope_i;
    int                                off_i;
    logic signed [llsf_pkg::IN_W-1:0]  x_base;
    logic signed [llsf_pkg::IN_W-1:0]  x;
    logic signed [llsf_pkg::IN_W-1:0]  y;
    roll = int'($urandom_range(99));
    if (roll < 6)       shape = SET_SINGLE;
    else if (roll < 16) shape = SET_FLAT_X;
    else if (roll < 30) shape = SET_EXTREME;
    else if (roll < 50) shape = SET_NOISE;
    else                shape = SET_LINE;
    size = ($urandom_range(99) < 4) ? int'($urandom_range(120, 20))
                                    : int'($urandom_range(8, 2));
    if (shape == SET_SINGLE) size = 1;
    x_base  = ($urandom_range(1) == 1) ? llsf_pkg::IN_W'($urandom)
                                       : llsf_pkg::IN_W'(int'($urandom_range(64)) - 32);
    slope_i = int'($urandom_range(128)) - 64;
    off_i   = int'($urandom_range(2000)) - 1000;
    for (i = 0; i < size; i++) begin
      case (shape)
        SET_FLAT_X: begin
          x = x_base;
          y = llsf_pkg::IN_W'($urandom);
        end
        SET_EXTREME: begin
          x = ($urandom_range(1) == 1) ? pick_extreme() : llsf_pkg::IN_W'($urandom);
          y = pick_extreme();
        end
        SET_LINE: begin
          dx = int'($urandom_range(1024)) - 512;
          x  = x_base + llsf_pkg::IN_W'(dx);
          y  = llsf_pkg::IN_W'(slope_i * dx + off_i + int'($urandom_range(8)) - 4);
        end
        default: begin
          x = llsf_pkg::IN_W'($urandom);
          y = llsf_pkg::IN_W'($urandom);
        end
      endcase
      send_point(x, y, i == size - 1);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int start;
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    start           = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_random_set();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_pt.valid      <= 1'b0;
    in_pt.x_value    <= '0;
    in_pt.y_value    <= '0;
    in_pt.last_point <= 1'b0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    items_sent      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point('0, '0, 1'b1);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MAX - llsf_pkg::IN_W'(1), COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MAX - llsf_pkg::IN_W'(1), COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MIN + llsf_pkg::IN_W'(1), COORD_MIN, 1'b1);
    send_point(llsf_pkg::IN_W'(5), llsf_pkg::IN_W'(1), 1'b0);
    send_point(llsf_pkg::IN_W'(5), llsf_pkg::IN_W'(100), 1'b0);
    send_point(llsf_pkg::IN_W'(5), llsf_pkg::IN_W'(-7), 1'b1);
    send_point('0, llsf_pkg::IN_W'(1), 1'b0);
    send_point(llsf_pkg::IN_W'(1), llsf_pkg::IN_W'(3), 1'b0);
    send_point(llsf_pkg::IN_W'(2), llsf_pkg::IN_W'(5), 1'b1);
    send_point('0, '0, 1'b0);
    send_point(llsf_pkg::IN_W'(3), llsf_pkg::IN_W'(1), 1'b1);

    // hold the sender until every fit is out
    wait_fits_drained();

    run_phase(0, 0);
    run_phase(74, 0);
    wait_fits_drained();
    run_phase(0, 74);
    run_phase(18, 18);

    wait_fits_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[linear_least_squares_fit_core] OK");
    end else begin
      $display("[linear_least_squares_fit_core] ERROR");
    end
    $finish;
  end

endmodule
